>>> rtl/core/crc_checked_frame_receiver_defines.svh
// assertion macros for the frame receiver
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CCFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ccfr_pkg.sv
package ccfr_pkg;

    localparam int FRAME_BYTES     = 1024;
    localparam int MAX_PACKET      = 64;
    localparam int WORDS_PER_FRAME = FRAME_BYTES / 4;
    localparam int FRAME_LEN       = WORDS_PER_FRAME * 4;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int WORD_W = 32;
    localparam int ADDR_W = 20;
    localparam int ASM_W  = 24;
    localparam int CMD_W  = 8;

    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam int IDX_W     = POS_W - 2;
    localparam int SUM_W     = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
    localparam int MAXP_W    = $clog2(MAX_PACKET + 1);
    localparam int LEN_CMP_W = (MAXP_W > LEN_W) ? MAXP_W : LEN_W;

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(WORDS_PER_FRAME - 1);
    localparam logic [ADDR_W-1:0] OFFSET_STEP = ADDR_W'(WORDS_PER_FRAME - 2);

    localparam logic [WORD_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // apb side
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic {
        REG_SENDING_CMD = 1'b0,
        REG_PROG_START  = 1'b1
    } t_reg_idx;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef struct packed {
        logic [CMD_W-1:0]  sending_command;
        logic [ADDR_W-1:0] program_start_word;
    } t_cfg;

    typedef struct packed {
        logic [LEN_W-1:0]  packet_length;
        logic              packet_start;
        logic [BYTE_W-1:0] data_byte;
    } t_item;

    typedef struct packed {
        t_kind             result_kind;
        logic [WORD_W-1:0] payload_word;
        logic [ADDR_W-1:0] word_address;
        logic              crc_match;
        logic              header_match;
        logic              frame_accepted;
    } t_result;

    typedef logic [WORD_W-1:0][WORD_W-1:0] t_crc_rows;

    // row i holds the input bits that feed output bit i after 32 shift steps
    function automatic t_crc_rows crc_rows();
        t_crc_rows         rows;
        logic [WORD_W-1:0] v;
        rows = '0;
        for (int j = 0; j < WORD_W; j++) begin
            v = WORD_W'(1) << j;
            for (int b = 0; b < WORD_W; b++) begin
                v = v[WORD_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
            end
            for (int i = 0; i < WORD_W; i++) begin
                rows[i][j] = v[i];
            end
        end
        return rows;
    endfunction

    localparam t_crc_rows CRC_ROWS = crc_rows();

    // one word of crc-32/mpeg-2 as a flat xor network
    function automatic logic [WORD_W-1:0] crc_step(logic [WORD_W-1:0] crc,
                                                   logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] res;
        c = crc ^ word;
        for (int i = 0; i < WORD_W; i++) begin
            res[i] = ^(c & CRC_ROWS[i]);
        end
        return res;
    endfunction

endpackage

>>> rtl/core/ccfr_apb_regs.sv
module ccfr_apb_regs import ccfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_SENDING_CMD: n_cfg.sending_command    = pwdata[CMD_W-1:0];
                REG_PROG_START:  n_cfg.program_start_word = pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SENDING_CMD: prdata = PDATA_W'(r_cfg.sending_command);
            REG_PROG_START:  prdata = PDATA_W'(r_cfg.program_start_word);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/ccfr_in_stage.sv
module ccfr_in_stage import ccfr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_fire,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // a held request leaves when the result side can move
    assign o_fire  = r_valid && i_advance;
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_item = r_item;

endmodule

>>> rtl/core/ccfr_frame_engine.sv
module ccfr_frame_engine import ccfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [ASM_W-1:0]  r_asm,    n_asm;
    logic [WORD_W-1:0] r_crc,    n_crc;
    logic [CMD_W-1:0]  r_header, n_header;
    logic [ADDR_W-1:0] r_offset, n_offset;
    logic [LEN_W-1:0]  r_drop,   n_drop;

    logic              take;
    logic [1:0]        lane;
    logic [IDX_W-1:0]  idx;
    logic [SUM_W-1:0]  fill_sum;
    logic              too_long;
    logic [WORD_W-1:0] word;
    logic [ADDR_W-1:0] base;
    logic              cm;
    logic              hm;

    assign lane     = r_pos[1:0];
    assign idx      = r_pos[POS_W-1:2];
    assign fill_sum = SUM_W'(r_pos) + SUM_W'(i_item.packet_length);
    assign too_long = (LEN_CMP_W'(i_item.packet_length) > LEN_CMP_W'(MAX_PACKET))
                      || (fill_sum > SUM_W'(FRAME_LEN));
    assign word     = {i_item.data_byte, r_asm};
    assign base     = i_cfg.program_start_word + r_offset;
    assign cm       = (r_crc == word);
    assign hm       = (r_header == i_cfg.sending_command);

    always_comb begin
        n_pos       = r_pos;
        n_asm       = r_asm;
        n_crc       = r_crc;
        n_header    = r_header;
        n_offset    = r_offset;
        n_drop      = r_drop;
        take        = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{result_kind: KIND_PAYLOAD, payload_word: word,
                        word_address: base + ADDR_W'(idx) - ADDR_W'(1),
                        crc_match: 1'b0, header_match: 1'b0, frame_accepted: 1'b0};

        // packet admission and drop bookkeeping
        if (i_item.packet_start) begin
            n_drop = '0;
            if (i_item.packet_length == '0) begin
                take = 1'b0;
            end else if (too_long) begin
                n_drop = i_item.packet_length - LEN_W'(1);
            end else begin
                take = 1'b1;
            end
        end else if (r_drop != '0) begin
            n_drop = r_drop - LEN_W'(1);
        end else begin
            take = 1'b1;
        end

        if (take) begin
            if (r_pos == '0) begin
                n_header = i_item.data_byte;
            end
            if (lane != 2'd3) begin
                n_asm = r_asm | (ASM_W'(i_item.data_byte) << {lane, 3'b000});
                n_pos = r_pos + POS_W'(1);
            end else begin
                n_asm = '0;
                if (idx != LAST_IDX) begin
                    n_crc       = crc_step(r_crc, word);
                    n_pos       = r_pos + POS_W'(1);
                    o_res_valid = (idx != '0);
                end else begin
                    // received crc word closes the frame
                    o_res_valid = 1'b1;
                    o_res       = '{result_kind: KIND_VERDICT, payload_word: r_crc,
                                    word_address: base, crc_match: cm,
                                    header_match: hm, frame_accepted: cm && hm};
                    if (cm && hm) begin
                        n_offset = r_offset + OFFSET_STEP;
                    end
                    n_pos = '0;
                    n_crc = CRC_INIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_asm    <= '0;
            r_crc    <= CRC_INIT;
            r_header <= '0;
            r_offset <= '0;
            r_drop   <= '0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_asm    <= n_asm;
            r_crc    <= n_crc;
            r_header <= n_header;
            r_offset <= n_offset;
            r_drop   <= n_drop;
        end
    end

endmodule

>>> rtl/core/crc_checked_frame_receiver.sv
// path: an accepted byte is held in the input stage register, then its result is registered in the output slot
// throughput: one byte per cycle while the output slot is free or being emptied, set by the frame state update
// (byte assembly plus the flat crc xor network on the fourth byte of each word)
// reset: synchronous active-low i_rst_n clears position, drop count, header,
// program offset and both stages, loads the crc with all ones; config goes to 0
`include "crc_checked_frame_receiver_defines.svh"

module crc_checked_frame_receiver import ccfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // apb configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // byte stream in
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,  // data_byte[7:0], packet_length[14:8], pad
    input  logic               s_axis_tuser,  // packet_start
    // result stream out
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [55:0]        m_axis_tdata,  // payload_word[31:0], word_address[51:32],
                                              // crc_match[52], header_match[53], pad
    output logic               m_axis_tuser,  // result_kind
    output logic               m_axis_tlast   // frame_accepted
);

    t_cfg    cfg;
    t_item   in_item;
    t_item   held_item;
    logic    advance;
    logic    fire;
    logic    res_valid;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    assign in_item = '{packet_length: s_axis_tdata[14:8],
                       packet_start:  s_axis_tuser,
                       data_byte:     s_axis_tdata[7:0]};

    // output slot is free or being emptied this cycle
    assign advance = !r_out_valid || m_axis_tready;

    ccfr_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ccfr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_fire    (fire),
        .o_item    (held_item)
    );

    ccfr_frame_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (held_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.header_match, r_out.crc_match,
                            r_out.word_address, r_out.payload_word};
    assign m_axis_tuser  = r_out.result_kind;
    assign m_axis_tlast  = r_out.frame_accepted;

    `CCFR_ASSERT_NOW(a_payload_flags_clear,
        m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD),
        !m_axis_tlast && (m_axis_tdata[53:52] == 2'b00),
        "payload result carries verdict flags")

    `CCFR_ASSERT_NOW(a_accept_is_both_matches,
        m_axis_tvalid && (m_axis_tuser == KIND_VERDICT),
        m_axis_tlast == (m_axis_tdata[52] && m_axis_tdata[53]),
        "frame acceptance disagrees with crc and header matches")

    `CCFR_ASSERT_NEXT(a_held_item_moves_on,
        fire && !(s_axis_tvalid && s_axis_tready),
        !u_in.o_fire,
        "input stage kept a consumed request")

endmodule

>>> tb/sv/tb_crc_checked_frame_receiver.sv
module tb_crc_checked_frame_receiver;
    import ccfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    // tracks the receiver's frame state and the results it owes
    class rx_frame_tracker;
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] prog_start;
        logic [POS_W-1:0]  byte_pos;
        logic [ASM_W-1:0]  partial_word;
        logic [WORD_W-1:0] crc_run;
        logic [CMD_W-1:0]  header;
        logic [ADDR_W-1:0] prog_offset;
        logic [LEN_W-1:0]  drop_left;
        t_result           results_due[$];
        int                kept_items;
        int                frames_done;
        int                errors;

        function new();
            command      = '0;
            prog_start   = '0;
            byte_pos     = '0;
            partial_word = '0;
            crc_run      = CRC_INIT;
            header       = '0;
            prog_offset  = '0;
            drop_left    = '0;
            kept_items   = 0;
            frames_done  = 0;
            errors       = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_SENDING_CMD: command    = val[CMD_W-1:0];
                REG_PROG_START:  prog_start = val[ADDR_W-1:0];
                default: ;
            endcase
        endfunction

        // crc-32/mpeg-2, one word, msb first
        function logic [WORD_W-1:0] crc_word(logic [WORD_W-1:0] crc, logic [WORD_W-1:0] word);
            logic [WORD_W-1:0] c;
            c = crc ^ word;
            for (int b = 0; b < WORD_W; b++) begin
                c = c[WORD_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            return c;
        endfunction

        function void take_byte(t_item it);
            logic [WORD_W-1:0] word;
            logic [ADDR_W-1:0] base;
            logic [1:0]        lane;
            logic [IDX_W-1:0]  idx;
            t_result           r;
            if (it.packet_start) begin
                drop_left = '0;
                if (it.packet_length == 0) return;
                if (it.packet_length > MAX_PACKET
                        || int'(byte_pos) + int'(it.packet_length) > FRAME_LEN) begin
                    drop_left = it.packet_length - 1'b1;
                    return;
                end
            end else if (drop_left != 0) begin
                drop_left--;
                return;
            end
            kept_items++;
            lane = byte_pos[1:0];
            idx  = byte_pos[POS_W-1:2];
            if (byte_pos == 0) header = it.data_byte;
            if (lane != 2'd3) begin
                partial_word |= ASM_W'(it.data_byte) << (8 * lane);
                byte_pos++;
                return;
            end
            word         = {it.data_byte, partial_word};
            partial_word = '0;
            base         = prog_start + prog_offset;
            r            = '0;
            if (idx != LAST_IDX) begin
                crc_run = crc_word(crc_run, word);
                byte_pos++;
                // header word is covered by the crc but never emitted
                if (idx == 0) return;
                r.result_kind  = KIND_PAYLOAD;
                r.payload_word = word;
                r.word_address = base + ADDR_W'(idx) - 1'b1;
                results_due.push_back(r);
                return;
            end
            r.result_kind    = KIND_VERDICT;
            r.payload_word   = crc_run;
            r.word_address   = base;
            r.crc_match      = (crc_run == word);
            r.header_match   = (header == command);
            r.frame_accepted = r.crc_match & r.header_match;
            results_due.push_back(r);
            if (r.frame_accepted) prog_offset += OFFSET_STEP;
            byte_pos = '0;
            crc_run  = CRC_INIT;
            frames_done++;
        endfunction

        function void check_field(string name, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (results_due.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = results_due.pop_front();
            check_field("result_kind", want.result_kind, got.result_kind);
            check_field("payload_word", want.payload_word, got.payload_word);
            check_field("word_address", want.word_address, got.word_address);
            check_field("crc_match", want.crc_match, got.crc_match);
            check_field("header_match", want.header_match, got.header_match);
            check_field("frame_accepted", want.frame_accepted, got.frame_accepted);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata  = '0;  // data_byte[7:0], packet_length[14:8], pad
    logic               s_axis_tuser  = 1'b0; // packet_start
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [55:0]        m_axis_tdata;  // payload_word[31:0], word_address[51:32],
                                       // crc_match[52], header_match[53], pad
    logic               m_axis_tuser;  // result_kind
    logic               m_axis_tlast;  // frame_accepted

    rx_frame_tracker tracker;
    t_result         rx_result;
    int              n_results   = 0;
    int              n_sent      = 0;
    int              hold_left   = 0;
    bit              hold_done   = 1'b0;
    int              n_cycles    = 0;
    bit              frm_bad_hdr;
    bit              frm_bad_crc;
    int              frm_bad_lane;

    crc_checked_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_crc_checked_frame_receiver failed");
            $finish;
        end
    end

    // result side: checks every accepted result and throttles tready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_result.result_kind    = t_kind'(m_axis_tuser);
                rx_result.payload_word   = m_axis_tdata[31:0];
                rx_result.word_address   = m_axis_tdata[51:32];
                rx_result.crc_match      = m_axis_tdata[52];
                rx_result.header_match   = m_axis_tdata[53];
                rx_result.frame_accepted = m_axis_tlast;
                tracker.match_result(rx_result);
                n_results++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (n_results >= HOLD_AT && !hold_done) begin
                // long hold-off so the pipeline backs up into the byte input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (n_results >= 100 && n_results < 220)
                                 || ($urandom_range(99) >= 31);
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send(logic [BYTE_W-1:0] b, logic st, logic [LEN_W-1:0] len);
        t_item it;
        it.data_byte     = b;
        it.packet_start  = st;
        it.packet_length = len;
        while (!(tracker.kept_items >= 400 && tracker.kept_items < 900)
                && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, len, b};
        s_axis_tuser  <= st;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        tracker.take_byte(it);
    endtask

    // a packet the receiver must throw away, sometimes cut short by the next start
    task automatic send_dropped(int len);
        int n;
        n = $urandom_range(1) ? len : $urandom_range(1, len);
        for (int k = 0; k < n; k++) begin
            send(8'($urandom), k == 0, k == 0 ? LEN_W'(len) : LEN_W'($urandom));
        end
    endtask

    // next kept byte: header at byte 0, the running crc in the last word
    function automatic logic [BYTE_W-1:0] frame_byte();
        int               lane;
        logic [BYTE_W-1:0] b;
        lane = int'(tracker.byte_pos) - (FRAME_LEN - 4);
        if (tracker.byte_pos == 0) begin
            b = frm_bad_hdr ? tracker.command ^ 8'($urandom_range(1, 255)) : tracker.command;
        end else if (lane >= 0) begin
            b = tracker.crc_run[8*lane +: 8];
            if (frm_bad_crc && lane == frm_bad_lane) b ^= 8'($urandom_range(1, 255));
        end else begin
            b = 8'($urandom);
        end
        return b;
    endfunction

    initial begin
        int roll;
        int room;
        int max_len;
        int pkt_len;
        int frame_goal;
        int n_frames;
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(REG_SENDING_CMD, 32'd0);
        write_reg(REG_PROG_START, 32'd0);

        // zero length start, then an oversized packet cut off by a real one
        send(8'hFF, 1'b1, 7'd0);
        send(8'h00, 1'b1, 7'd127);
        send(8'hFF, 1'b0, 7'd127);
        send(8'h00, 1'b0, 7'd0);
        send(tracker.command, 1'b1, 7'd8);
        send(8'hFF, 1'b0, 7'd0);
        send(8'h00, 1'b0, 7'd127);
        send(8'h80, 1'b0, 7'd0);
        send(8'h01, 1'b0, 7'd127);
        send(8'h7F, 1'b0, 7'd0);
        send(8'hFE, 1'b0, 7'd127);
        send(8'h55, 1'b0, 7'd0);
        // untagged bytes outside a drop are frame bytes
        send(8'h12, 1'b0, 7'd0);
        send(8'h34, 1'b0, 7'd127);
        send(8'h56, 1'b0, 7'd64);
        send(8'h78, 1'b0, 7'd1);
        send(8'hAA, 1'b1, 7'd65);
        send(8'h55, 1'b0, 7'd0);
        send(8'hFF, 1'b1, 7'd4);
        send(8'hFF, 1'b0, 7'd0);
        send(8'h00, 1'b0, 7'd0);
        send(8'hFF, 1'b0, 7'd0);

        n_frames = 0;
        while (n_sent < RANDOM_ITEMS) begin
            if (n_frames == 1) begin
                write_reg(REG_SENDING_CMD, 32'd255);
                write_reg(REG_PROG_START, 32'hFFFFF);
            end else if (n_frames == 2) begin
                write_reg(REG_SENDING_CMD, 32'($urandom_range(1, 254)));
                // base sits just under the top so payload addresses wrap
                write_reg(REG_PROG_START, 32'(20'hFFFFF - 20'd254 - 20'($urandom_range(0, 200))));
            end else if (n_frames > 2) begin
                write_reg(REG_SENDING_CMD, 32'($urandom_range(0, 255)));
                write_reg(REG_PROG_START, 32'($urandom_range(0, 20'hFFFFF)));
            end
            frm_bad_crc  = (n_frames == 1) || (n_frames > 2 && $urandom_range(99) < 20);
            frm_bad_hdr  = (n_frames == 2) || (n_frames > 2 && $urandom_range(99) < 20);
            frm_bad_lane = $urandom_range(0, 3);

            frame_goal = tracker.frames_done + 1;
            while (tracker.frames_done < frame_goal && n_sent < RANDOM_ITEMS) begin
                roll = $urandom_range(99);
                room = FRAME_LEN - int'(tracker.byte_pos);
                if (roll < 4) begin
                    send(8'($urandom), 1'b1, 7'd0);
                end else if (roll < 8) begin
                    send_dropped($urandom_range(MAX_PACKET + 1, 127));
                end else if (roll < 11) begin
                    send(frame_byte(), 1'b0, LEN_W'($urandom));
                end else if (roll < 40 && room < MAX_PACKET) begin
                    // packet that would run past the end of the frame
                    send_dropped($urandom_range(room + 1, MAX_PACKET));
                end else begin
                    max_len = (room < MAX_PACKET) ? room : MAX_PACKET;
                    roll    = $urandom_range(99);
                    if (roll < 15) pkt_len = max_len;
                    else if (roll < 25) pkt_len = 1;
                    else pkt_len = $urandom_range(1, max_len);
                    for (int k = 0; k < pkt_len; k++) begin
                        send(frame_byte(), k == 0, k == 0 ? LEN_W'(pkt_len) : LEN_W'($urandom));
                    end
                end
            end

            // hold the byte stream until every result of the frame is back
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (tracker.results_due.size() != 0);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            n_frames++;
        end

        if (tracker.errors == 0 && tracker.results_due.size() == 0) begin
            $display("tb_crc_checked_frame_receiver passed");
        end else begin
            $display("tb_crc_checked_frame_receiver failed");
        end
        $finish;
    end

endmodule
